// ----- sv/sensor_scan_max_mean_defines.svh -----
// Assertion macros used by the checker file of the sensor scan block.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef SENSOR_SCAN_MAX_MEAN_DEFINES_SVH
`define SENSOR_SCAN_MAX_MEAN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSMM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Consequent must hold in the cycle after the antecedent.
`define SSMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// ----- sv/ssmm_pkg.sv -----
// Package of the sensor scan max/mean block: widths, register codes, shared types.
// Depends on nothing; every module of the block refers to it by scoped names.
package ssmm_pkg;

    localparam int MAX_SENSORS = 64;
    localparam int POS_W       = $clog2(MAX_SENSORS + 1);
    localparam int TEMP_W      = 12;
    localparam int GROUP_W     = 8;
    localparam int TAG_W       = 16;
    localparam int SUM_W       = 19;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int HIGH_W      = 11;
    localparam int SCAN_W      = 32;
    localparam int DVD_W       = SUM_W - 1;
    localparam int REM_W       = CNT_W;
    localparam int DIV_STEPS   = DVD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_GROUP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_THRESHOLD = 1'd1;

    localparam logic [GROUP_W-1:0]       EXCLUDED_RESET  = 8'd32;
    localparam logic signed [TEMP_W-1:0] THRESHOLD_RESET = 12'sd2016;

    // operation for the shared adder/subtractor
    typedef struct packed {
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic             sub;
    } alu_op_t;

    // per-item decision of the filter
    typedef struct packed {
        logic working;
        logic new_best;
    } verdict_t;

endpackage

// ----- sv/ssmm_alu.sv -----
// Shared adder/subtractor: accumulates readings, takes the magnitude, divides, negates.
// Depends on ssmm_pkg.
module ssmm_alu (
    input  ssmm_pkg::alu_op_t           op,
    output logic [ssmm_pkg::SUM_W-1:0] result
);

    assign result = op.sub ? (op.a - op.b) : (op.a + op.b);

endmodule

// ----- sv/ssmm_filter.sv -----
// Per-item filter: decides whether a reading counts and whether it is a new maximum.
// Depends on ssmm_pkg.
module ssmm_filter (
    input  logic                                sensor_present,
    input  logic signed [ssmm_pkg::TEMP_W-1:0]  reading,
    input  logic [ssmm_pkg::TAG_W-1:0]          user_tag,
    input  logic [ssmm_pkg::GROUP_W-1:0]        excluded_group,
    input  logic signed [ssmm_pkg::TEMP_W-1:0]  fault_threshold,
    input  logic [ssmm_pkg::POS_W-1:0]          position,
    input  logic signed [ssmm_pkg::TEMP_W-1:0]  best_value,
    output ssmm_pkg::verdict_t                  verdict
);

    logic in_range;
    logic group_ok;

    assign in_range = position < ssmm_pkg::POS_W'(ssmm_pkg::MAX_SENSORS);
    assign group_ok = user_tag[ssmm_pkg::TAG_W-1 -: ssmm_pkg::GROUP_W] != excluded_group;

    always_comb
    begin
        verdict.working  = sensor_present && in_range && group_ok
                           && (reading < fault_threshold);
        // only a strictly higher reading moves the maximum
        verdict.new_best = verdict.working && (reading > best_value);
    end

endmodule

// ----- sv/sensor_scan_max_mean.sv -----
// Sensor scan max/mean: running maximum, argmax, sum and count; mean at scan end.
// Throughput: one item per cycle for items without last_of_scan; a last item holds
// in_ready low in S_ABS, S_DIV, S_SIGN and S_HOLD while the shared adder divides.
// The result is registered on leaving S_HOLD, which waits while the previous result
// is still held. rst_n (async, low) clears state, restores config.
module sensor_scan_max_mean (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                sensor_present,
    input  logic signed [ssmm_pkg::TEMP_W-1:0]  reading,
    input  logic [ssmm_pkg::TAG_W-1:0]          user_tag,
    input  logic                                last_of_scan,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssmm_pkg::HIGH_W-1:0]         highest,
    output logic [ssmm_pkg::IDX_W-1:0]          highest_index,
    output logic signed [ssmm_pkg::TEMP_W-1:0]  mean,
    output logic [ssmm_pkg::CNT_W-1:0]          working_count,
    output logic [ssmm_pkg::SCAN_W-1:0]         scan_number,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ssmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_HOLD
    } state_t;

    state_t state_reg, state_next;

    logic [ssmm_pkg::GROUP_W-1:0]       excl_reg, excl_next;
    logic signed [ssmm_pkg::TEMP_W-1:0] thr_reg, thr_next;

    logic [ssmm_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic signed [ssmm_pkg::TEMP_W-1:0] best_reg, best_next;
    logic [ssmm_pkg::IDX_W-1:0]         best_pos_reg, best_pos_next;
    logic [ssmm_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [ssmm_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [ssmm_pkg::SCAN_W-1:0]        scan_reg, scan_next;

    logic                               neg_reg, neg_next;
    logic [ssmm_pkg::DVD_W-1:0]         dvd_reg, dvd_next;
    logic [ssmm_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [ssmm_pkg::STEP_W-1:0]        step_reg, step_next;
    logic signed [ssmm_pkg::TEMP_W-1:0] quot_reg, quot_next;

    logic                               out_valid_reg, out_valid_next;
    logic [ssmm_pkg::HIGH_W-1:0]        highest_reg, highest_next;
    logic [ssmm_pkg::IDX_W-1:0]         hidx_reg, hidx_next;
    logic signed [ssmm_pkg::TEMP_W-1:0] mean_reg, mean_next;
    logic [ssmm_pkg::CNT_W-1:0]         wcount_reg, wcount_next;

    ssmm_pkg::verdict_t                 verdict;
    ssmm_pkg::alu_op_t                  alu_op;
    logic [ssmm_pkg::SUM_W-1:0]         alu_result;
    logic [ssmm_pkg::REM_W:0]           trial;
    logic                               fits;
    logic                               in_fire;
    logic                               in_range;

    ssmm_filter u_filter (
        .sensor_present  (sensor_present),
        .reading         (reading),
        .user_tag        (user_tag),
        .excluded_group  (excl_reg),
        .fault_threshold (thr_reg),
        .position        (pos_reg),
        .best_value      (best_reg),
        .verdict         (verdict)
    );

    ssmm_alu u_alu (
        .op     (alu_op),
        .result (alu_result)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign in_range  = pos_reg < ssmm_pkg::POS_W'(ssmm_pkg::MAX_SENSORS);
    assign trial     = {rem_reg, dvd_reg[ssmm_pkg::DVD_W-1]};
    assign fits      = !alu_result[ssmm_pkg::SUM_W-1];

    assign out_valid     = out_valid_reg;
    assign highest       = highest_reg;
    assign highest_index = hidx_reg;
    assign mean          = mean_reg;
    assign working_count = wcount_reg;
    assign scan_number   = scan_reg;

    always_comb
    begin
        state_next     = state_reg;
        excl_next      = excl_reg;
        thr_next       = thr_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        best_pos_next  = best_pos_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        neg_next       = neg_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        quot_next      = quot_reg;
        out_valid_next = out_valid_reg;
        highest_next   = highest_reg;
        hidx_next      = hidx_reg;
        mean_next      = mean_reg;
        wcount_next    = wcount_reg;

        alu_op.a   = sum_reg;
        alu_op.b   = {{(ssmm_pkg::SUM_W - ssmm_pkg::TEMP_W){reading[ssmm_pkg::TEMP_W-1]}},
                      reading};
        alu_op.sub = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssmm_pkg::REG_EXCLUDED_GROUP:  excl_next = cfg_data[ssmm_pkg::GROUP_W-1:0];
                ssmm_pkg::REG_FAULT_THRESHOLD: thr_next  = $signed(cfg_data);
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (sensor_present && in_range)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (verdict.working)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = alu_result;
                    end
                    if (verdict.new_best)
                    begin
                        best_next     = reading;
                        best_pos_next = pos_reg[ssmm_pkg::IDX_W-1:0];
                    end
                    if (last_of_scan)
                    begin
                        state_next = S_ABS;
                    end
                end
            end

            S_ABS:
            begin
                // take the magnitude of the sum as dividend
                alu_op.a   = '0;
                alu_op.b   = sum_reg;
                alu_op.sub = 1'b1;
                neg_next   = sum_reg[ssmm_pkg::SUM_W-1];
                dvd_next   = sum_reg[ssmm_pkg::SUM_W-1] ? alu_result[ssmm_pkg::DVD_W-1:0]
                                                        : sum_reg[ssmm_pkg::DVD_W-1:0];
                rem_next   = '0;
                step_next  = ssmm_pkg::STEP_W'(ssmm_pkg::DIV_STEPS - 1);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                // one restoring step: shift in a dividend bit, try to subtract the count
                alu_op.a   = ssmm_pkg::SUM_W'(trial);
                alu_op.b   = ssmm_pkg::SUM_W'(count_reg);
                alu_op.sub = 1'b1;
                rem_next   = fits ? alu_result[ssmm_pkg::REM_W-1:0]
                                  : trial[ssmm_pkg::REM_W-1:0];
                dvd_next   = {dvd_reg[ssmm_pkg::DVD_W-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            S_SIGN:
            begin
                alu_op.a   = '0;
                alu_op.b   = ssmm_pkg::SUM_W'(dvd_reg);
                alu_op.sub = 1'b1;
                if (count_reg == '0)
                begin
                    quot_next = '0;
                end
                else if (neg_reg)
                begin
                    quot_next = $signed(alu_result[ssmm_pkg::TEMP_W-1:0]);
                end
                else
                begin
                    quot_next = $signed(dvd_reg[ssmm_pkg::TEMP_W-1:0]);
                end
                state_next = S_HOLD;
            end

            S_HOLD:
            begin
                // wait for the output register, then load it and clear the scan
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    highest_next   = best_reg[ssmm_pkg::HIGH_W-1:0];
                    hidx_next      = best_pos_reg;
                    mean_next      = quot_reg;
                    wcount_next    = count_reg;
                    scan_next      = scan_reg + 1'b1;
                    pos_next       = '0;
                    best_next      = '0;
                    best_pos_next  = '0;
                    sum_next       = '0;
                    count_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            excl_reg      <= ssmm_pkg::EXCLUDED_RESET;
            thr_reg       <= ssmm_pkg::THRESHOLD_RESET;
            pos_reg       <= '0;
            best_reg      <= '0;
            best_pos_reg  <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            neg_reg       <= 1'b0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            quot_reg      <= '0;
            out_valid_reg <= 1'b0;
            highest_reg   <= '0;
            hidx_reg      <= '0;
            mean_reg      <= '0;
            wcount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            excl_reg      <= excl_next;
            thr_reg       <= thr_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            best_pos_reg  <= best_pos_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            neg_reg       <= neg_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            step_reg      <= step_next;
            quot_reg      <= quot_next;
            out_valid_reg <= out_valid_next;
            highest_reg   <= highest_next;
            hidx_reg      <= hidx_next;
            mean_reg      <= mean_next;
            wcount_reg    <= wcount_next;
        end
    end

endmodule

// ----- sv/ssmm_checker.sv -----
// Port-level checker for sensor_scan_max_mean, bound to the top level.
// Depends on ssmm_pkg and sensor_scan_max_mean_defines.svh.
`include "sensor_scan_max_mean_defines.svh"

module ssmm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                sensor_present,
    input logic signed [ssmm_pkg::TEMP_W-1:0]  reading,
    input logic [ssmm_pkg::TAG_W-1:0]          user_tag,
    input logic                                last_of_scan,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [ssmm_pkg::HIGH_W-1:0]         highest,
    input logic [ssmm_pkg::IDX_W-1:0]          highest_index,
    input logic signed [ssmm_pkg::TEMP_W-1:0]  mean,
    input logic [ssmm_pkg::CNT_W-1:0]          working_count,
    input logic [ssmm_pkg::SCAN_W-1:0]         scan_number,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [ssmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [ssmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // a stalled result holds
    `SSMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(highest) && $stable(mean) && $stable(scan_number))

    // the end of a scan starts the divide, so input stalls next cycle
    `SSMM_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_of_scan, !in_ready)

    // an empty scan reports zero maximum, position and mean
    `SSMM_ASSERT_SAME(a_empty_scan, out_valid && working_count == '0,
        highest == '0 && highest_index == '0 && mean == '0)

    // back-to-back results carry consecutive scan numbers
    `SSMM_ASSERT_NEXT(a_scan_step, out_valid && out_ready,
        !out_valid || scan_number == $past(scan_number) + 1'b1)

endmodule

bind sensor_scan_max_mean ssmm_checker u_ssmm_checker (.*);
